FILE: rtl/lcst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light colour state table package
// Shared types, operation codes and sizes for the light table core and its
// colour arithmetic unit.
// ----------------------------------------------------------------------------
package lcst_pkg;

    localparam int MAX_LIGHTS_DEF = 16;
    localparam int COUNT_W        = 5;
    localparam int TDATA_IN_W     = 40;
    localparam int TDATA_OUT_W    = 40;

    localparam logic [1:0] OP_SET_BRI  = 2'd0;
    localparam logic [1:0] OP_SET_HS   = 2'd1;
    localparam logic [1:0] OP_SET_FULL = 2'd2;
    localparam logic [1:0] OP_READ     = 2'd3;

    localparam logic [7:0]  CHAN_FULL  = 8'd255;
    localparam logic [16:0] HUE_ONE    = 17'h10000;
    localparam logic [24:0] CHAN_SCALE = 25'h0FF0000;

    // One stored light entry, 57 bits.
    typedef struct packed {
        logic        on;
        logic [7:0]  bri;
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } entry_t;

    typedef struct packed {
        logic start;
        logic use_hsv;
    } arith_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } arith_rsp_t;

endpackage

FILE: rtl/light_colour_state_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light colour state table core
// Keeps on flag, brightness, hue, saturation and RGB colour per light in a
// synchronous memory, and updates the colour on brightness or hue changes.
// ----------------------------------------------------------------------------
// Every item passes IDLE, READ and FINISH; an update to an index in range
// also passes CALC, where a brightness update waits on the 8-step
// bit-serial rescale divider. One item is in work at a time, and FINISH
// waits until the output register is free.
// Reset clears the device count and marks every entry as all-zero through
// per-entry valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module light_colour_state_table_core
#(
    parameter int MAX_LIGHTS = lcst_pkg::MAX_LIGHTS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration: device_count, written whenever cfg_wr_en is high.
    input  logic                               cfg_wr_en,
    input  logic [lcst_pkg::COUNT_W-1:0]       cfg_wr_data,
    // Input items. From bit 0: operation[1:0], device_index[5:2],
    // power_on[6], brightness[14:7], hue_in[30:15], saturation[38:31], pad.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lcst_pkg::TDATA_IN_W-1:0]    s_tdata,
    // Result items. From bit 0: found[0], is_on[1], level[9:2], red[17:10],
    // green[25:18], blue[33:26], zero pad above.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lcst_pkg::TDATA_OUT_W-1:0]   m_tdata
);
    import lcst_pkg::*;

    localparam int IDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_CALC   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] dev_count_reg;
    logic [MAX_LIGHTS-1:0] valid_reg;

    // The light table itself: one read port, one write port.
    entry_t mem [MAX_LIGHTS];
    entry_t rd_reg;
    logic   ent_valid_reg;

    // Captured input item.
    logic [1:0]       op_reg;
    logic [IDX_W-1:0] addr_reg;
    logic             on_reg;
    logic [7:0]       bri_reg;
    logic [15:0]      hue_reg;
    logic [7:0]       sat_reg;
    logic             found_reg;

    // Entry under construction, written back and reported when done.
    entry_t work_reg, work_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;

    logic [1:0]       s_op;
    logic [3:0]       s_idx;
    logic [IDX_W-1:0] s_addr;
    logic             s_accept;
    logic             s_in_range;
    logic             out_free;
    logic             finish_now;
    logic             mem_we;

    entry_t     stored_c;
    entry_t     merged_c;
    arith_req_t arith_req;
    arith_rsp_t arith_rsp;

    assign s_op   = s_tdata[1:0];
    assign s_idx  = s_tdata[5:2];
    assign s_addr = IDX_W'(s_idx);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // An index must be below the programmed count and below the table size.
    assign s_in_range = ({1'b0, s_idx} < dev_count_reg) && (int'(s_idx) < MAX_LIGHTS);

    // An entry that was never written reads as all zero.
    assign stored_c = ent_valid_reg ? rd_reg : '0;

    // Fields the operation replaces; the colour is filled in by the arithmetic.
    always_comb
    begin
        merged_c = stored_c;
        case (op_reg)
            OP_SET_BRI:
            begin
                merged_c.on  = on_reg;
                merged_c.bri = bri_reg;
            end
            OP_SET_HS:
            begin
                merged_c.hue = hue_reg;
                merged_c.sat = sat_reg;
            end
            OP_SET_FULL:
            begin
                merged_c.on  = on_reg;
                merged_c.bri = bri_reg;
                merged_c.hue = hue_reg;
                merged_c.sat = sat_reg;
            end
            default:
            begin
                merged_c = stored_c;
            end
        endcase
    end

    assign arith_req.start   = (state_reg == ST_READ) && found_reg && (op_reg != OP_READ);
    assign arith_req.use_hsv = (op_reg != OP_SET_BRI);

    lcst_arith u_arith
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (arith_req),
        .operand (merged_c),
        .rsp     (arith_rsp)
    );

    // The output register is free when empty or being drained this cycle.
    assign out_free   = !m_tvalid_reg || m_tready;
    assign finish_now = (state_reg == ST_FINISH) && out_free;
    assign mem_we     = finish_now && found_reg && (op_reg != OP_READ);

    always_comb
    begin
        state_next = state_reg;
        work_next  = work_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // Rejected items report all zero; reads report the entry as is.
                if (!found_reg)
                begin
                    work_next  = '0;
                    state_next = ST_FINISH;
                end
                else if (op_reg == OP_READ)
                begin
                    work_next  = stored_c;
                    state_next = ST_FINISH;
                end
                else
                begin
                    work_next  = merged_c;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (arith_rsp.done)
                begin
                    work_next.red   = arith_rsp.red;
                    work_next.green = arith_rsp.green;
                    work_next.blue  = arith_rsp.blue;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (finish_now)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dev_count_reg <= '0;
            valid_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                dev_count_reg <= cfg_wr_data;
            end
            if (mem_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (s_accept)
        begin
            op_reg        <= s_op;
            addr_reg      <= s_addr;
            on_reg        <= s_tdata[6];
            bri_reg       <= s_tdata[14:7];
            hue_reg       <= s_tdata[30:15];
            sat_reg       <= s_tdata[38:31];
            found_reg     <= s_in_range;
            ent_valid_reg <= valid_reg[s_addr];
        end
        if (finish_now)
        begin
            m_tdata_reg <= {6'd0, work_reg.blue, work_reg.green, work_reg.red,
                            work_reg.bri, work_reg.on, found_reg};
        end
    end

    // Light table memory with registered read data. Reads and writes never
    // overlap on the same entry because one item is in work at a time.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= work_reg;
        end
        if (s_accept)
        begin
            rd_reg <= mem[s_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/lcst_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light colour arithmetic unit
// Rescales a stored colour to a new brightness with three bit-serial
// dividers, or converts hue and saturation to a scaled RGB colour.
// ----------------------------------------------------------------------------
module lcst_arith
(
    input  logic                clk,
    input  logic                rst_n,
    input  lcst_pkg::arith_req_t req,
    input  lcst_pkg::entry_t     operand,
    output lcst_pkg::arith_rsp_t rsp
);
    import lcst_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       hsv_reg;

    // Divider lanes: partial remainder and dividend bits that turn into quotient.
    logic [7:0] rem_reg [3];
    logic [7:0] low_reg [3];
    logic [7:0] big_reg;
    logic       zero_reg;

    // Conversion path.
    logic [23:0] fs_reg;
    logic [24:0] ft_reg;
    logic [2:0]  sector_reg;
    logic [7:0]  sat_reg;
    logic [7:0]  bri_reg;
    logic [7:0]  ch_reg  [3];
    logic [7:0]  hsv_res [3];

    logic [7:0]  in_ch [3];
    logic [7:0]  big_c;
    logic [18:0] hue_x6;
    logic [15:0] frac_c;
    logic [7:0]  p_c, q_c, t_c;
    logic [23:0] q_diff;
    logic [24:0] t_diff;
    logic [7:0]  sel_c [3];

    assign in_ch[0] = operand.red;
    assign in_ch[1] = operand.green;
    assign in_ch[2] = operand.blue;

    always_comb
    begin
        big_c = operand.red;
        if (operand.green > big_c)
        begin
            big_c = operand.green;
        end
        if (operand.blue > big_c)
        begin
            big_c = operand.blue;
        end
    end

    assign hue_x6 = 19'(operand.hue) * 19'd6;
    assign frac_c = hue_x6[15:0];

    assign p_c    = CHAN_FULL - sat_reg;
    assign q_diff = CHAN_SCALE[23:0] - fs_reg;
    assign t_diff = CHAN_SCALE - ft_reg;
    assign q_c    = q_diff[23:16];
    assign t_c    = t_diff[23:16];

    always_comb
    begin
        case (sector_reg)
            3'd0:
            begin
                sel_c[0] = CHAN_FULL; sel_c[1] = t_c;       sel_c[2] = p_c;
            end
            3'd1:
            begin
                sel_c[0] = q_c;       sel_c[1] = CHAN_FULL; sel_c[2] = p_c;
            end
            3'd2:
            begin
                sel_c[0] = p_c;       sel_c[1] = CHAN_FULL; sel_c[2] = t_c;
            end
            3'd3:
            begin
                sel_c[0] = p_c;       sel_c[1] = q_c;       sel_c[2] = CHAN_FULL;
            end
            3'd4:
            begin
                sel_c[0] = t_c;       sel_c[1] = p_c;       sel_c[2] = CHAN_FULL;
            end
            default:
            begin
                sel_c[0] = CHAN_FULL; sel_c[1] = p_c;       sel_c[2] = q_c;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 3'd1;
            if ((!hsv_reg && cnt_reg == 3'd7) || (hsv_reg && cnt_reg == 3'd1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [15:0] prod;
        logic [8:0]  trial;
        logic        ge;
        if (req.start)
        begin
            hsv_reg    <= req.use_hsv;
            big_reg    <= big_c;
            zero_reg   <= (big_c == 8'd0);
            fs_reg     <= 24'(frac_c) * 24'(operand.sat);
            ft_reg     <= 25'(HUE_ONE - 17'(frac_c)) * 25'(operand.sat);
            sector_reg <= hue_x6[18:16];
            sat_reg    <= operand.sat;
            bri_reg    <= operand.bri;
            for (int i = 0; i < 3; i++)
            begin
                prod       = 16'(in_ch[i]) * 16'(operand.bri);
                rem_reg[i] <= prod[15:8];
                low_reg[i] <= prod[7:0];
            end
        end
        else if (busy_reg && !hsv_reg)
        begin
            // One quotient bit per lane per cycle; the quotient never exceeds 255.
            for (int i = 0; i < 3; i++)
            begin
                trial      = {rem_reg[i], low_reg[i][7]};
                ge         = (trial >= {1'b0, big_reg});
                rem_reg[i] <= ge ? 8'(trial - {1'b0, big_reg}) : trial[7:0];
                low_reg[i] <= {low_reg[i][6:0], ge};
            end
        end
        else if (busy_reg && hsv_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cnt_reg == 3'd0)
                begin
                    ch_reg[i] <= sel_c[i];
                end
                else
                begin
                    prod       = 16'(ch_reg[i]) * 16'(bri_reg);
                    hsv_res[i] <= prod[15:8];
                end
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.red   = hsv_reg ? hsv_res[0] : (zero_reg ? 8'd0 : low_reg[0]);
    assign rsp.green = hsv_reg ? hsv_res[1] : (zero_reg ? 8'd0 : low_reg[1]);
    assign rsp.blue  = hsv_reg ? hsv_res[2] : (zero_reg ? 8'd0 : low_reg[2]);

endmodule

FILE: tb/tb_light_colour_state_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light colour state table core testbench
// Sends command items (brightness, hue/saturation, full state and read) into
// the light table over the input stream and checks every result item against
// a table model or a hand-typed value. A short directed table comes first,
// then random traffic under four idling patterns and several device counts.
// ----------------------------------------------------------------------------
module tb_light_colour_state_table_core;

    import lcst_pkg::*;

    // The run is stopped by the watchdog if it goes on this many cycles.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Number of random items sent in each random phase.
    localparam int ITEMS_PER_PHASE = 88;
    localparam int PHASE_COUNT     = 8;

    // One command item, as the sender sees it.
    typedef struct {
        logic [1:0]  op;
        logic [3:0]  idx;
        logic        on;
        logic [7:0]  bri;
        logic [15:0] hue;
        logic [7:0]  sat;
    } light_cmd_t;

    // One result item, as the receiver sees it.
    typedef struct {
        logic       found;
        logic       is_on;
        logic [7:0] level;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } light_result_t;

    // One row of the directed table. A row may write the device count first,
    // and may carry a result that is typed in by hand.
    typedef struct {
        bit            cfg_wr;
        logic [4:0]    cfg_val;
        light_cmd_t    cmd;
        bit            typed;
        light_result_t res;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]     cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // From bit 0: operation, device_index, power_on, brightness, hue_in,
    // saturation, one zero pad bit.
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // From bit 0: found, is_on, level, red, green, blue, zero pad.
    logic [TDATA_OUT_W-1:0] m_tdata;

    // Model of the table: the stored entries and the device count in force.
    entry_t                 light_table [MAX_LIGHTS_DEF];
    logic [4:0]             active_count;

    // Results that the block still owes, oldest first.
    light_result_t          pending_results [$];
    directed_row_t          directed_rows [$];

    // Percent of cycles in which the sender holds back or the receiver stalls.
    int unsigned            tx_idle_pct = 0;
    int unsigned            rx_stall_pct = 0;

    int unsigned            mismatch_count = 0;
    int unsigned            cycle_count = 0;
    int unsigned            results_seen = 0;

    light_colour_state_table_core u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The watchdog ends a run that hangs, for instance on a lost result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate that the current phase sets.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Recompute the stored colour from hue and saturation: six sectors around
    // the hue circle, a 16-bit fraction within the sector, then a scale by
    // brightness over 256. All steps round down.
    function automatic void colour_from_hue_sat(inout entry_t e);
        int unsigned x;
        int unsigned sector;
        int unsigned frac;
        int unsigned s;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        x      = e.hue * 6;
        sector = x >> 16;
        frac   = x & 32'h0000_FFFF;
        s      = e.sat;
        p      = 255 - s;
        q      = (255 * 65536 - frac * s) >> 16;
        t      = (255 * 65536 - (65536 - frac) * s) >> 16;
        case (sector)
            0:
            begin
                r = 255; g = t;   b = p;
            end
            1:
            begin
                r = q;   g = 255; b = p;
            end
            2:
            begin
                r = p;   g = 255; b = t;
            end
            3:
            begin
                r = p;   g = q;   b = 255;
            end
            4:
            begin
                r = t;   g = p;   b = 255;
            end
            default:
            begin
                r = 255; g = p;   b = q;
            end
        endcase
        e.red   = 8'((r * e.bri) >> 8);
        e.green = 8'((g * e.bri) >> 8);
        e.blue  = 8'((b * e.bri) >> 8);
    endfunction

    // Rescale the stored colour so that its largest channel equals the new
    // brightness. A black colour stays black.
    function automatic void rescale_to_level(inout entry_t e);
        int unsigned peak;
        int unsigned ch;
        peak = e.red;
        if (e.green > peak)
            peak = e.green;
        if (e.blue > peak)
            peak = e.blue;
        if (peak == 0)
        begin
            e.red   = '0;
            e.green = '0;
            e.blue  = '0;
        end
        else
        begin
            ch      = e.red;
            e.red   = 8'(ch * e.bri / peak);
            ch      = e.green;
            e.green = 8'(ch * e.bri / peak);
            ch      = e.blue;
            e.blue  = 8'(ch * e.bri / peak);
        end
    endfunction

    // Apply one command to the table model and return the result it gives.
    // A count above the table size acts as the table size; since the index
    // is only four bits wide, the count compare alone decides rejection.
    function automatic light_result_t predict_light_result(input light_cmd_t c);
        light_result_t res;
        entry_t        e;
        res = '{default: '0};
        if (c.idx >= active_count)
            return res;
        e = light_table[c.idx];
        case (c.op)
            OP_SET_BRI:
            begin
                e.on  = c.on;
                e.bri = c.bri;
                rescale_to_level(e);
            end
            OP_SET_HS:
            begin
                e.hue = c.hue;
                e.sat = c.sat;
                colour_from_hue_sat(e);
            end
            OP_SET_FULL:
            begin
                e.on  = c.on;
                e.bri = c.bri;
                e.hue = c.hue;
                e.sat = c.sat;
                colour_from_hue_sat(e);
            end
            default:
            begin
            end
        endcase
        light_table[c.idx] = e;
        res.found = 1'b1;
        res.is_on = e.on;
        res.level = e.bri;
        res.red   = e.red;
        res.green = e.green;
        res.blue  = e.blue;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every accepted result item is matched against the oldest one owed.
    always @(posedge clk)
    begin
        light_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result item with no command waiting for it");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("found", want.found, m_tdata[0]);
                check_field("is_on", want.is_on, m_tdata[1]);
                check_field("level", want.level, m_tdata[9:2]);
                check_field("red",   want.red,   m_tdata[17:10]);
                check_field("green", want.green, m_tdata[25:18]);
                check_field("blue",  want.blue,  m_tdata[33:26]);
            end
        end
    end

    // Write the device count. The block must be idle: the sender drops
    // valid, waits for every owed result, and lets the tail of the longest
    // operation drain before the write.
    task automatic write_device_count(input logic [4:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (14) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        active_count = value;
    endtask

    // Send one command item, with random idle cycles ahead of it. Valid stays
    // high from one item to the next when no idle cycle falls between them.
    // Once the item is taken, the model is updated and the result is queued;
    // a hand-typed result takes the place of the predicted one.
    task automatic issue_cmd(input light_cmd_t c, input bit typed,
                             input light_result_t typed_res);
        light_result_t res;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {1'b0, c.sat, c.hue, c.bri, c.on, c.idx, c.op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = predict_light_result(c);
        if (typed)
            pending_results.insert(pending_results.size(), typed_res);
        else
            pending_results.insert(pending_results.size(), res);
    endtask

    task automatic add_row(input bit cfg_wr, input logic [4:0] cfg_val,
                           input logic [1:0] op, input logic [3:0] idx, input logic on,
                           input logic [7:0] bri, input logic [15:0] hue,
                           input logic [7:0] sat, input bit typed, input logic found,
                           input logic is_on, input logic [7:0] level,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue);
        directed_row_t row;
        row.cfg_wr  = cfg_wr;
        row.cfg_val = cfg_val;
        row.cmd     = '{op, idx, on, bri, hue, sat};
        row.typed   = typed;
        row.res     = '{found, is_on, level, red, green, blue};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    initial
    begin
        light_cmd_t    c;
        light_result_t none;
        logic [4:0]    phase_counts [PHASE_COUNT];
        int unsigned   reach;
        int unsigned   directed_items;
        int unsigned   random_items;

        none = '{default: '0};
        foreach (light_table[i])
            light_table[i] = '0;
        active_count   = '0;
        directed_items = 0;
        random_items   = 0;

        // Directed table. Columns: count write, count, op, index, on, level,
        // hue, saturation, then a hand-typed result where one is obvious.
        // With a zero count every index is rejected and the result is all zero.
        add_row(1, 0,  OP_READ,     0,  0, 8'h00, 16'h0000, 8'h00, 1, 0, 0, 0, 0, 0, 0);
        // After reset every entry reads back as zero.
        add_row(1, 16, OP_READ,     0,  0, 8'h00, 16'h0000, 8'h00, 1, 1, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_READ,     15, 0, 8'h00, 16'h0000, 8'h00, 1, 1, 0, 0, 0, 0, 0);
        // Rescaling a black colour keeps it black.
        add_row(0, 0,  OP_SET_BRI,  0,  1, 8'hFF, 16'h0000, 8'h00, 1, 1, 1, 255, 0, 0, 0);
        // Pure red at full level: 255 * 255 / 256 rounds down to 254.
        add_row(0, 0,  OP_SET_FULL, 1,  1, 8'hFF, 16'h0000, 8'hFF, 1, 1, 1, 255, 254, 0, 0);
        // No saturation gives white.
        add_row(0, 0,  OP_SET_FULL, 2,  1, 8'hFF, 16'h0000, 8'h00, 1, 1, 1, 255, 254, 254, 254);
        // Zero level blanks the colour whatever hue and saturation say.
        add_row(0, 0,  OP_SET_FULL, 3,  0, 8'h00, 16'hFFFF, 8'hFF, 1, 1, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_FULL, 15, 1, 8'hFF, 16'hFFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_HS,   1,  0, 8'h00, 16'h5555, 8'h80, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_BRI,  1,  1, 8'd100, 16'h0000, 8'h00, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_BRI,  1,  0, 8'h00, 16'h0000, 8'h00, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_BRI,  4,  1, 8'h01, 16'h0000, 8'h00, 1, 1, 1, 1, 0, 0, 0);
        add_row(0, 0,  OP_SET_HS,   5,  0, 8'h00, 16'hFFFF, 8'hFF, 1, 1, 0, 0, 0, 0, 0);
        // One hue in each of the remaining five sectors.
        add_row(0, 0,  OP_SET_FULL, 6,  1, 8'hC8, 16'h2AAB, 8'hC8, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_FULL, 7,  1, 8'hC8, 16'h5556, 8'hC8, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_FULL, 8,  1, 8'hC8, 16'h8000, 8'hC8, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_FULL, 9,  1, 8'hC8, 16'hAAAB, 8'hC8, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_FULL, 10, 1, 8'hC8, 16'hD556, 8'hC8, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_BRI,  6,  1, 8'hFF, 16'h0000, 8'h00, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_READ,     15, 0, 8'h00, 16'h0000, 8'h00, 0, 0, 0, 0, 0, 0, 0);
        // A count above the table size acts as the table size.
        add_row(1, 31, OP_READ,     15, 0, 8'h00, 16'h0000, 8'h00, 0, 0, 0, 0, 0, 0, 0);
        // With one entry in use, index one and up are rejected and untouched.
        add_row(1, 1,  OP_READ,     1,  0, 8'h00, 16'h0000, 8'h00, 1, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_FULL, 0,  1, 8'hAA, 16'h1234, 8'h55, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_SET_BRI,  15, 1, 8'hFF, 16'h0000, 8'h00, 1, 0, 0, 0, 0, 0, 0);
        add_row(0, 0,  OP_READ,     0,  0, 8'h00, 16'h0000, 8'h00, 0, 0, 0, 0, 0, 0, 0);

        // Reset is held low at the start and released on a rising edge.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cfg_wr)
                write_device_count(directed_rows[i].cfg_val);
            issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
            directed_items++;
        end

        // Random phases. Each phase writes a new device count, the oversized
        // ones among them, and cycles through four idling patterns: none,
        // sender mostly idle, receiver mostly stalled, and light idling on both.
        phase_counts = '{5'd16, 5'd31, 5'd1, 5'd9, 5'd16, 5'd5, 5'd12, 5'd17};
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_device_count(phase_counts[p]);
            case (p % 4)
                0:
                begin
                    tx_idle_pct = 0;  rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 83; rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;  rx_stall_pct = 83;
                end
                default:
                begin
                    tx_idle_pct = 8;  rx_stall_pct = 8;
                end
            endcase
            reach = (phase_counts[p] > MAX_LIGHTS_DEF) ? MAX_LIGHTS_DEF : phase_counts[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Most items address an entry in use, so that state builds
                // up; about one in ten may land on any index.
                c.op = 2'($urandom_range(3));
                if ($urandom_range(9) != 0)
                    c.idx = 4'($urandom_range(reach - 1));
                else
                    c.idx = 4'($urandom_range(15));
                c.on = 1'($urandom_range(1));
                case ($urandom_range(7))
                    0:       c.bri = 8'h00;
                    1:       c.bri = 8'hFF;
                    default: c.bri = 8'($urandom_range(255));
                endcase
                case ($urandom_range(7))
                    0:       c.hue = 16'h0000;
                    1:       c.hue = 16'hFFFF;
                    default: c.hue = 16'($urandom_range(65535));
                endcase
                case ($urandom_range(7))
                    0:       c.sat = 8'h00;
                    1:       c.sat = 8'hFF;
                    default: c.sat = 8'($urandom_range(255));
                endcase
                issue_cmd(c, 1'b0, none);
                random_items++;
            end
        end

        // Drain: stop sending, wait for every owed result, then give the
        // block time to show any stray result.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Sent %0d directed and %0d random command items, %0d results checked.",
                 directed_items, random_items, results_seen);
        $display("Device counts from 0 to 31 and four sender/receiver idling patterns.");
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
